// ===== rtl/core/eudst_pkg.sv =====
// eudst_pkg: payload types, calendar constants and small helper functions
// for the European summer time flag block.
// No dependencies; compiled first.
package eudst_pkg;

	// input item: rtc date as bcd bytes
	typedef struct packed {
		logic [7:0] year_bcd;
		logic [7:0] month_bcd;
		logic [7:0] day_bcd;
	} date_t;

	// result item
	typedef struct packed {
		logic summer_time;
	} flag_t;

	// months that matter for the rule
	localparam logic [7:0] MONTH_MARCH     = 8'd3;
	localparam logic [7:0] MONTH_APRIL     = 8'd4;
	localparam logic [7:0] MONTH_SEPTEMBER = 8'd9;
	localparam logic [7:0] MONTH_OCTOBER   = 8'd10;

	// last day examined for the changeover sunday
	localparam logic [4:0] LAST_DAY = 5'd31;

	// decoded year from which the year counts in the 22nd century
	localparam logic [7:0] CENTURY_STEP = 8'd100;

	// folded zeller constants: offset from the last day back to sunday is
	// (y + y/4 - century + ofs) mod 7, with ofs set by the month
	localparam logic [7:0] MARCH_OFS   = 8'd5;
	localparam logic [7:0] OCTOBER_OFS = 8'd2;

	localparam logic [3:0] SEVEN = 4'd7;

	// high*10 + low, digits not checked
	function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = b[7:4];
		lo = b[3:0];
		return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
	endfunction

	// remainder by seven through octal digit folding (8 = 1 mod 7)
	function automatic logic [2:0] mod7(input logic [7:0] v);
		logic [4:0] t1;
		logic [3:0] t2;
		t1 = {3'b000, v[7:6]} + {2'b00, v[5:3]} + {2'b00, v[2:0]};
		t2 = {2'b00, t1[4:3]} + {1'b0, t1[2:0]};
		if (t2 >= SEVEN) begin
			t2 = t2 - SEVEN;
		end
		return t2[2:0];
	endfunction

endpackage

// ===== rtl/core/eudst_stream_if.sv =====
// eudst_stream_if: valid/ready channel with a typed payload.
// Depends on nothing; the payload type is passed in by the user.
interface eudst_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/eudst_rule.sv =====
// eudst_rule: combinational summer time rule for one date.
// Depends on eudst_pkg (constants, bcd decode, mod 7).
module eudst_rule (
	input  eudst_pkg::date_t date,
	output logic             summer_time
);
	import eudst_pkg::*;

	logic [7:0] year;
	logic [7:0] month;
	logic [7:0] day;
	logic [7:0] year_sum;
	logic [7:0] folded;
	logic [2:0] back_days;
	logic [4:0] last_sunday;

	// decode bcd bytes
	assign year  = bcd_to_bin(date.year_bcd);
	assign month = bcd_to_bin(date.month_bcd);
	assign day   = bcd_to_bin(date.day_bcd);

	// leap year terms; year/400 is constant over 2000..2165
	assign year_sum = year + {2'b00, year[7:2]} - {7'd0, (year >= CENTURY_STEP)};

	// days from the 31st back to the last sunday
	assign folded      = year_sum + ((month == MONTH_MARCH) ? MARCH_OFS : OCTOBER_OFS);
	assign back_days   = mod7(folded);
	assign last_sunday = LAST_DAY - {2'b00, back_days};

	// month windows
	always_comb begin
		priority if (month >= MONTH_APRIL && month <= MONTH_SEPTEMBER) begin
			summer_time = 1'b1;
		end else if (month == MONTH_MARCH) begin
			summer_time = (day >= {3'b000, last_sunday});
		end else if (month == MONTH_OCTOBER) begin
			summer_time = (day <= {3'b000, last_sunday});
		end else begin
			summer_time = 1'b0;
		end
	end

endmodule

// ===== rtl/core/eu_dst_flag_from_bcd_date.sv =====
// eu_dst_flag_from_bcd_date: top level of the summer time flag block.
// Depends on eudst_pkg, eudst_stream_if and eudst_rule.
//
// Usage:
//   date_in  (sink) takes one item per date: bcd year 20YY, month, day.
//   flag_out (source) gives one item per date: summer_time, 1 inside the
//   European summer time period (april to september, march from its last
//   sunday, october up to and including its last sunday).
// Path: an accepted date is held in the input register, passes the rule
//   logic and is held in the result register; flag_out.valid rises when
//   the result register takes it, which a held flag_out can delay.
// Throughput: one date per cycle while flag_out.ready is high, set by the
//   single pass of decode, mod 7 fold and compare between the two registers.
// Reset: arst_n clears both valid bits at once; no item is in flight
//   afterwards and date_in is ready in the first cycle.
// Stall: while flag_out is held, the result register keeps its item and
//   the input register still takes one more date; date_in.ready drops
//   only when both registers are full and flag_out.ready is low.
module eu_dst_flag_from_bcd_date (
	input  logic            clk,
	input  logic            arst_n,
	eudst_stream_if.sink    date_in,
	eudst_stream_if.source  flag_out
);
	import eudst_pkg::*;

	logic  valid_s1;
	date_t date_s1;
	logic  valid_s2;
	flag_t flag_s2;
	logic  advance_s2;
	logic  advance_s1;
	logic  flag_comb;

	// stall control
	assign advance_s2   = !valid_s2 || flag_out.ready;
	assign advance_s1   = !valid_s1 || advance_s2;
	assign date_in.ready = advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= date_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && date_in.valid) begin
			date_s1 <= date_in.payload;
		end
	end

	// rule logic
	eudst_rule u_rule (
		.date        (date_s1),
		.summer_time (flag_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			flag_s2.summer_time <= flag_comb;
		end
	end

	assign flag_out.valid   = valid_s2;
	assign flag_out.payload = flag_s2;

endmodule

// ===== rtl/core/eudst_checker.sv =====
// eudst_checker: port-level assertions for the summer time flag block,
// bound to the top level below.
// Depends on eu_dst_flag_from_bcd_date and eudst_stream_if.
module eudst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_month_bcd,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_summer_time
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// held result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_summer_time))
		else $error("result changed while stalled");

	// an accepted date shows up through the input and result registers when the sink is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc ##1 out_ready) |=> out_valid)
		else $error("result missing after two cycles");

	// april to september always give summer time
	a_summer_months: assert property (@(posedge clk) disable iff (!arst_n)
		((in_acc && (in_month_bcd == 8'h04 || in_month_bcd == 8'h05 ||
		  in_month_bcd == 8'h06 || in_month_bcd == 8'h07 ||
		  in_month_bcd == 8'h08 || in_month_bcd == 8'h09)) ##1 out_ready)
		|=> out_valid && out_summer_time)
		else $error("summer month flagged as winter");

	// months with a bcd high digit of 2 or more never give summer time
	a_far_months: assert property (@(posedge clk) disable iff (!arst_n)
		((in_acc && in_month_bcd[7:5] != 3'b000) ##1 out_ready)
		|=> out_valid && !out_summer_time)
		else $error("out of range month flagged as summer");

endmodule

bind eu_dst_flag_from_bcd_date eudst_checker u_eudst_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (date_in.valid),
	.in_ready        (date_in.ready),
	.in_month_bcd    (date_in.payload.month_bcd),
	.out_valid       (flag_out.valid),
	.out_ready       (flag_out.ready),
	.out_summer_time (flag_out.payload.summer_time)
);

// ===== tb/tb_eu_dst_flag_from_bcd_date.sv =====
// tb_eu_dst_flag_from_bcd_date: self-checking bench for the summer time flag block,
// directed dates from a table, then random dates under bursty input and a stalling output.
// Depends on eudst_pkg, eudst_stream_if and eu_dst_flag_from_bcd_date.
module tb_eu_dst_flag_from_bcd_date;
	timeunit 1ns;
	timeprecision 1ps;

	import eudst_pkg::*;

	localparam int YEAR_BASE = 2000;
	localparam int NUM_RANDOM = 550;
	localparam int HOLD_AFTER = 150;
	localparam int HOLD_CYCLES = 64;
	localparam int MAX_SHOWN = 10;

	// how a table row gets its expected flag
	typedef enum logic [1:0] {
		WANT_OFF,
		WANT_ON,
		WANT_PREDICTED
	} want_t;

	typedef struct packed {
		logic [7:0] yy;
		logic [7:0] mm;
		logic [7:0] dd;
		want_t      want;
	} date_row_t;

	localparam int NUM_ROWS = 25;

	logic clk = 1'b0;
	logic arst_n;

	eudst_stream_if #(.payload_t(date_t)) date_in ();
	eudst_stream_if #(.payload_t(flag_t)) flag_out ();

	eu_dst_flag_from_bcd_date dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.date_in  (date_in),
		.flag_out (flag_out)
	);

	logic flags_due [$];
	int dates_sent = 0;
	int mismatches = 0;
	bit hold_done = 1'b0;

	// directed dates: extremes, every month class, both sides of each last sunday
	date_row_t date_rows [NUM_ROWS] = '{
		'{8'h00, 8'h00, 8'h00, WANT_OFF},        // month zero
		'{8'hFF, 8'hFF, 8'hFF, WANT_OFF},        // all bits set, month decodes to 165
		'{8'h99, 8'h13, 8'h15, WANT_OFF},        // month thirteen
		'{8'h00, 8'h0F, 8'h10, WANT_OFF},        // bad low digit, month 15
		'{8'h00, 8'h01, 8'h01, WANT_OFF},
		'{8'h99, 8'h12, 8'h31, WANT_OFF},
		'{8'h24, 8'h02, 8'h29, WANT_OFF},
		'{8'h24, 8'h04, 8'h01, WANT_ON},
		'{8'h00, 8'h09, 8'h30, WANT_ON},
		'{8'hFF, 8'h06, 8'hFF, WANT_ON},         // bad digits elsewhere, mid summer
		'{8'h24, 8'h03, 8'h30, WANT_PREDICTED},  // day before last sunday of march
		'{8'h24, 8'h03, 8'h31, WANT_PREDICTED},  // last sunday on day 31
		'{8'h25, 8'h03, 8'h29, WANT_PREDICTED},
		'{8'h25, 8'h03, 8'h30, WANT_PREDICTED},
		'{8'h24, 8'h10, 8'h27, WANT_PREDICTED},  // last sunday of october
		'{8'h24, 8'h10, 8'h28, WANT_PREDICTED},
		'{8'h25, 8'h10, 8'h26, WANT_PREDICTED},
		'{8'h25, 8'h10, 8'h27, WANT_PREDICTED},
		'{8'h00, 8'h03, 8'h40, WANT_ON},         // march day past month end
		'{8'hFF, 8'h03, 8'h00, WANT_OFF},        // march day zero
		'{8'h00, 8'h10, 8'h00, WANT_ON},         // october day zero
		'{8'h99, 8'h10, 8'hFF, WANT_OFF},        // october day 165
		'{8'h1A, 8'h03, 8'h31, WANT_PREDICTED},  // bad year digit
		'{8'h00, 8'h0A, 8'h05, WANT_PREDICTED},  // bad month digit decodes to october
		'{8'h99, 8'h03, 8'h25, WANT_PREDICTED}
	};

	always #5 clk = ~clk;

	// decode a bcd byte without checking the digits
	function automatic int bcd_value(input logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	function automatic logic [7:0] to_bcd(input int n);
		return 8'(((n / 10) << 4) | (n % 10));
	endfunction

	// expected summer time flag for one date
	function automatic logic summer_time_of(input date_t d);
		int yr;
		int mo;
		int dy;
		int zeller;
		int weekday;
		int last_sun;
		yr = YEAR_BASE + bcd_value(d.year_bcd);
		mo = bcd_value(d.month_bcd);
		dy = bcd_value(d.day_bcd);
		// weekday of day 31, monday is 0
		zeller = (int'(LAST_DAY) + (13 * (mo + 1)) / 5 + yr + yr / 4
			- yr / 100 + yr / 400) % 7;
		weekday = (zeller + 5) % 7;
		last_sun = int'(LAST_DAY) - (weekday + 1) % 7;
		if (mo >= int'(MONTH_APRIL) && mo <= int'(MONTH_SEPTEMBER)) begin
			return 1'b1;
		end else if (mo == int'(MONTH_MARCH)) begin
			return dy >= last_sun;
		end else if (mo == int'(MONTH_OCTOBER)) begin
			return dy <= last_sun;
		end
		return 1'b0;
	endfunction

	// offer one date from a falling edge, return at the falling edge after acceptance
	task automatic send_date(input date_t d, input logic due);
		date_in.valid <= 1'b1;
		date_in.payload <= d;
		@(posedge clk);
		while (!date_in.ready) begin
			@(posedge clk);
		end
		flags_due.push_back(due);
		dates_sent++;
		@(negedge clk);
	endtask

	// random date, mostly well formed with weight on the changeover months
	function automatic date_t random_date();
		date_t d;
		int pick;
		int mo;
		pick = $urandom_range(0, 99);
		d.year_bcd = to_bcd($urandom_range(0, 99));
		if (pick < 40) begin
			mo = ($urandom_range(0, 1) != 0) ? int'(MONTH_MARCH) : int'(MONTH_OCTOBER);
			d.month_bcd = to_bcd(mo);
			d.day_bcd = to_bcd($urandom_range(18, 31));
		end else if (pick < 70) begin
			d.month_bcd = to_bcd($urandom_range(1, 12));
			d.day_bcd = to_bcd($urandom_range(1, 31));
		end else if (pick < 80) begin
			d.month_bcd = to_bcd($urandom_range(0, 99));
			d.day_bcd = to_bcd($urandom_range(0, 99));
		end else begin
			d = date_t'(24'($urandom));
		end
		return d;
	endfunction

	// reset, directed table, random dates, then drain
	initial begin
		int burst_left;
		int gap;
		date_t d;
		date_in.valid = 1'b0;
		date_in.payload = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (date_rows[i]) begin
			d.year_bcd = date_rows[i].yy;
			d.month_bcd = date_rows[i].mm;
			d.day_bcd = date_rows[i].dd;
			case (date_rows[i].want)
				WANT_OFF: begin
					send_date(d, 1'b0);
				end
				WANT_ON: begin
					send_date(d, 1'b1);
				end
				default: begin
					send_date(d, summer_time_of(d));
				end
			endcase
		end

		// bursts of random length with random gaps, some runs back to back
		burst_left = 0;
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					date_in.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			d = random_date();
			send_date(d, summer_time_of(d));
		end
		date_in.valid <= 1'b0;

		while (flags_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// output side: stall patterns in segments, one long hold-off mid run
	initial begin
		int mode;
		int run;
		flag_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			run = $urandom_range(8, 60);
			for (int i = 0; i < run; i++) begin
				@(negedge clk);
				if (!hold_done && dates_sent >= HOLD_AFTER) begin
					flag_out.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_done = 1'b1;
				end else begin
					case (mode)
						0: flag_out.ready <= 1'b1;
						1: flag_out.ready <= 1'($urandom_range(0, 1));
						default: flag_out.ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// compare each flag item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && flag_out.valid && flag_out.ready) begin
			if (flags_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("unexpected flag item %b at %0t", flag_out.payload.summer_time, $realtime);
				end
			end else if (flag_out.payload.summer_time !== flags_due[0]) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("summer_time mismatch at %0t: expected %b, got %b",
						$realtime, flags_due[0], flag_out.payload.summer_time);
				end
				void'(flags_due.pop_front());
			end else begin
				void'(flags_due.pop_front());
			end
		end
	end

	// watchdog
	initial begin
		#2ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
